### sv/fpgd_pkg.sv
// shared types and constants for the packet descriptor generator
// used by every module of the block; no dependencies
package fpgd_pkg;

  // build-time defaults handed to the top level
  localparam int FLOWS_PER_SOURCE = 8;
  localparam int MAX_QUEUES       = 8;
  localparam int QUEUE_SLOTS      = 2048;

  // generator arithmetic
  localparam logic [31:0] LCG_MUL = 32'd214013;
  localparam logic [31:0] LCG_ADD = 32'd2531011;
  localparam logic [13:0] LEN_BASE = 14'd64;

  // field widths
  localparam int LEN_W    = 14;
  localparam int FLOW_W   = 7;
  localparam int SUB_W    = 3;
  localparam int SEQ_W    = 32;
  localparam int QUEUE_W  = 3;
  localparam int SLOT_W   = $clog2(QUEUE_SLOTS);
  localparam int POS_W    = 14;   // partition positions up to 7*2047+2046
  localparam int PSIZE_W  = 11;
  localparam int NUM_SUBFLOWS = 8;

  // stream data widths, padded to whole bytes
  localparam int IN_DATA_W  = 8;
  localparam int OUT_FIELDS_W = LEN_W + FLOW_W + SEQ_W + QUEUE_W + SLOT_W;
  localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  // queue between front and back
  localparam int FIFO_DEPTH = 2;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_LENGTH_SEED     = 3'd0,
    REG_FLOW_SEED       = 3'd1,
    REG_SOURCE_COUNT    = 3'd2,
    REG_QUEUE_COUNT     = 3'd3,
    REG_SOURCE_NUMBER   = 3'd4,
    REG_PARTITION_SLOTS = 3'd5
  } cfg_reg_t;

  // classification settings used by the front
  typedef struct packed {
    logic [3:0] source_count;
    logic [3:0] queue_count;
    logic [2:0] source_number;
  } cls_cfg_t;

  // generator seed loads
  typedef struct packed {
    logic        len_load;
    logic        flow_load;
    logic [31:0] value;
  } seed_wr_t;

  // partition settings used by the back
  typedef struct packed {
    logic             reload;
    logic [POS_W-1:0] reload_start;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] last;
  } slot_cfg_t;

  // one classified item between front and back
  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [FLOW_W-1:0]  flow;
    logic [SUB_W-1:0]   sub;
    logic [QUEUE_W-1:0] queue;
  } desc_t;

endpackage

### sv/fpgd_front.sv
// front end: accepts tick items, runs both generators and picks the queue
// depends on fpgd_pkg
module fpgd_front #(
  parameter int FLOWS_PER_SOURCE = fpgd_pkg::FLOWS_PER_SOURCE,
  parameter int MAX_QUEUES       = fpgd_pkg::MAX_QUEUES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fpgd_pkg::cls_cfg_t  cls_cfg,
  input  fpgd_pkg::seed_wr_t  seed_wr,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                tick,
  input  logic                fifo_full,
  output logic                push,
  output fpgd_pkg::desc_t     push_desc
);

  logic [31:0] len_state_r, len_state_nxt;
  logic [31:0] flow_state_r, flow_state_nxt;
  logic [31:0] len_step, flow_step;
  logic [fpgd_pkg::SUB_W-1:0]  sub;
  logic [fpgd_pkg::FLOW_W-1:0] flow;
  logic [3:0] mask;
  logic [3:0] qc;
  logic [3:0] q_raw;
  logic       fire;

  assign in_tready = !fifo_full;
  assign fire      = in_tvalid && in_tready && tick;
  assign push      = fire;

  // next generator values
  assign len_step  = fpgd_pkg::LCG_MUL * len_state_r + fpgd_pkg::LCG_ADD;
  assign flow_step = fpgd_pkg::LCG_MUL * flow_state_r + fpgd_pkg::LCG_ADD;

  // flow number from the sub-flow and the source offset
  assign sub  = flow_step[18:16];
  assign flow = fpgd_pkg::FLOW_W'({4'b0, sub})
              + fpgd_pkg::FLOW_W'(fpgd_pkg::FLOW_W'(cls_cfg.source_number)
                                  * fpgd_pkg::FLOW_W'(FLOWS_PER_SOURCE))
              + fpgd_pkg::FLOW_W'(1);

  // queue mask from source count, queue count clamped to the available queues
  always_comb begin
    if (cls_cfg.source_count >= 4'd7) mask = 4'd15;
    else if (cls_cfg.source_count >= 4'd5) mask = 4'd7;
    else if (cls_cfg.source_count >= 4'd3) mask = 4'd3;
    else mask = 4'd1;

    if (cls_cfg.queue_count == 4'd0) qc = 4'd1;
    else if (cls_cfg.queue_count > 4'(MAX_QUEUES)) qc = 4'(MAX_QUEUES);
    else qc = cls_cfg.queue_count;
  end

  // out-of-range queue falls back to queue zero
  always_comb begin
    q_raw = flow[3:0] & mask;
    if (q_raw > (qc - 4'd1)) q_raw = 4'd0;
  end

  always_comb begin
    push_desc.len   = fpgd_pkg::LEN_W'({1'b0, len_step[28:16]}) + fpgd_pkg::LEN_BASE;
    push_desc.flow  = flow;
    push_desc.sub   = sub;
    push_desc.queue = q_raw[fpgd_pkg::QUEUE_W-1:0];
  end

  // generator state: seed loads win, otherwise step on each tick
  always_comb begin
    len_state_nxt  = len_state_r;
    flow_state_nxt = flow_state_r;
    if (fire) begin
      len_state_nxt  = len_step;
      flow_state_nxt = flow_step;
    end
    if (seed_wr.len_load) len_state_nxt = seed_wr.value;
    if (seed_wr.flow_load) flow_state_nxt = seed_wr.value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_state_r  <= 32'd1;
      flow_state_r <= 32'd1;
    end else begin
      len_state_r  <= len_state_nxt;
      flow_state_r <= flow_state_nxt;
    end
  end

endmodule

### sv/fpgd_queue.sv
// short descriptor queue between front and back
// depends on fpgd_pkg
module fpgd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fpgd_pkg::desc_t  push_desc,
  input  logic             pop,
  output fpgd_pkg::desc_t  head_desc,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (fpgd_pkg::FIFO_DEPTH > 1) ? $clog2(fpgd_pkg::FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(fpgd_pkg::FIFO_DEPTH + 1);

  fpgd_pkg::desc_t entries_r [fpgd_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty     = (count_r == CNT_W'(0));
  assign full      = (count_r == CNT_W'(fpgd_pkg::FIFO_DEPTH));
  assign head_desc = entries_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(fpgd_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(fpgd_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) count_nxt = count_r + CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_desc;
  end

endmodule

### sv/fpgd_back.sv
// back end: per-sub-flow sequence counters, per-queue write slots, output register
// depends on fpgd_pkg
module fpgd_back #(
  parameter int MAX_QUEUES = fpgd_pkg::MAX_QUEUES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fpgd_pkg::slot_cfg_t               slot_cfg,
  input  fpgd_pkg::desc_t                   head_desc,
  input  logic                              empty,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [fpgd_pkg::LEN_W-1:0]        out_len,
  output logic [fpgd_pkg::FLOW_W-1:0]       out_flow,
  output logic [fpgd_pkg::SEQ_W-1:0]        out_seq,
  output logic [fpgd_pkg::QUEUE_W-1:0]      out_queue,
  output logic [fpgd_pkg::SLOT_W-1:0]       out_slot
);

  localparam int QIDX_W = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;

  logic [fpgd_pkg::SEQ_W-1:0] seq_cnt_r [fpgd_pkg::NUM_SUBFLOWS];
  logic [fpgd_pkg::POS_W-1:0] slot_r [MAX_QUEUES];
  logic                       out_valid_r, out_valid_nxt;
  logic [fpgd_pkg::LEN_W-1:0]   len_r;
  logic [fpgd_pkg::FLOW_W-1:0]  flow_r;
  logic [fpgd_pkg::SEQ_W-1:0]   seq_r;
  logic [fpgd_pkg::QUEUE_W-1:0] queue_r;
  logic [fpgd_pkg::SLOT_W-1:0]  wslot_r;

  logic [QIDX_W-1:0]            qi;
  logic [fpgd_pkg::SEQ_W-1:0]   seq_cur;
  logic [fpgd_pkg::POS_W-1:0]   slot_cur;
  logic [fpgd_pkg::POS_W:0]     slot_inc;
  logic [fpgd_pkg::POS_W-1:0]   slot_nxt;

  // take the head item when the output register is free or draining
  assign pop = !empty && (!out_valid_r || out_tready);

  assign qi       = head_desc.queue[QIDX_W-1:0];
  assign seq_cur  = seq_cnt_r[head_desc.sub];
  assign slot_cur = slot_r[qi];

  // slot walks through the partition and wraps to its start
  assign slot_inc = {1'b0, slot_cur} + (fpgd_pkg::POS_W + 1)'(1);
  assign slot_nxt = (slot_inc > {1'b0, slot_cfg.last}) ? slot_cfg.start
                                                       : slot_inc[fpgd_pkg::POS_W-1:0];

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  // per-sub-flow counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fpgd_pkg::NUM_SUBFLOWS; i++) seq_cnt_r[i] <= '0;
    end else if (pop) begin
      seq_cnt_r[head_desc.sub] <= seq_cur + fpgd_pkg::SEQ_W'(1);
    end
  end

  // per-queue write slots, reloaded when the partition changes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_QUEUES; i++) slot_r[i] <= '0;
    end else if (slot_cfg.reload) begin
      for (int i = 0; i < MAX_QUEUES; i++) slot_r[i] <= slot_cfg.reload_start;
    end else if (pop) begin
      slot_r[qi] <= slot_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      len_r   <= head_desc.len;
      flow_r  <= head_desc.flow;
      seq_r   <= seq_cur;
      queue_r <= head_desc.queue;
      wslot_r <= slot_cur[fpgd_pkg::SLOT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_len    = len_r;
  assign out_flow   = flow_r;
  assign out_seq    = seq_r;
  assign out_queue  = queue_r;
  assign out_slot   = wslot_r;

endmodule

### sv/flow_packet_generator_dispatch.sv
// top level of the packet descriptor generator: configuration registers,
// front end, descriptor queue and back end; depends on fpgd_pkg and all fpgd_ modules
//
// Usage:
//  - in_* channel: one item per tick request; tick is in_tdata[0]. An item with
//    tick low is taken and dropped without advancing anything.
//  - out_* channel: one packet descriptor per tick item, in order.
//  - cfg_* port: write enable, register index and data; the write lands at the
//    clock edge with cfg_wr_en high. Seed writes reload the generators, source
//    number and partition writes reload all queue write slots. Write only while idle.
// Path: an accepted tick item enters the descriptor queue, then the output register.
// Throughput: one item per cycle sustained while out_tready stays high; the generator
//  step (one constant multiply and add per generator) and the counter/slot update are
//  combinational in front of their registers.
// Reset: rst_n low empties the queue, clears out_tvalid, loads both generator
//  states with 1, all sequence counters with 0, all write slots with 0, and the
//  registers with their defaults.
// Stall: while out_tready is low the output register holds; the two-entry queue
//  keeps taking items until it fills, then in_tready drops.
module flow_packet_generator_dispatch #(
  parameter int FLOWS_PER_SOURCE = fpgd_pkg::FLOWS_PER_SOURCE,
  parameter int MAX_QUEUES       = fpgd_pkg::MAX_QUEUES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: [0] tick, rest zero
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [fpgd_pkg::IN_DATA_W-1:0]     in_tdata,
  // out_tdata: [13:0] packet_length, [20:14] flow_id, [52:21] sequence_number,
  //            [55:53] target_queue, [66:56] write_slot, rest zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [fpgd_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [2:0]                         cfg_idx,
  input  logic [31:0]                        cfg_wdata
);

  localparam int OUT_PAD_W = fpgd_pkg::OUT_DATA_W - fpgd_pkg::OUT_FIELDS_W;

  fpgd_pkg::cls_cfg_t  cls_cfg_r, cls_cfg_nxt;
  logic [fpgd_pkg::PSIZE_W-1:0] psize_r, psize_nxt;
  logic [fpgd_pkg::PSIZE_W-1:0] psize_eff;
  logic [fpgd_pkg::POS_W-1:0]   start_r, start_nxt;
  logic [fpgd_pkg::POS_W-1:0]   last_r, last_nxt;
  logic                         reload;
  fpgd_pkg::seed_wr_t  seed_wr;
  fpgd_pkg::slot_cfg_t slot_cfg;
  fpgd_pkg::desc_t     push_desc, head_desc;
  logic push, pop, fifo_empty, fifo_full;

  logic [fpgd_pkg::LEN_W-1:0]   out_len;
  logic [fpgd_pkg::FLOW_W-1:0]  out_flow;
  logic [fpgd_pkg::SEQ_W-1:0]   out_seq;
  logic [fpgd_pkg::QUEUE_W-1:0] out_queue;
  logic [fpgd_pkg::SLOT_W-1:0]  out_slot;

  // register write decode
  always_comb begin
    cls_cfg_nxt       = cls_cfg_r;
    psize_nxt         = psize_r;
    reload            = 1'b0;
    seed_wr.len_load  = 1'b0;
    seed_wr.flow_load = 1'b0;
    seed_wr.value     = cfg_wdata;
    if (cfg_wr_en) begin
      unique case (fpgd_pkg::cfg_reg_t'(cfg_idx))
        fpgd_pkg::REG_LENGTH_SEED:   seed_wr.len_load = 1'b1;
        fpgd_pkg::REG_FLOW_SEED:     seed_wr.flow_load = 1'b1;
        fpgd_pkg::REG_SOURCE_COUNT:  cls_cfg_nxt.source_count = cfg_wdata[3:0];
        fpgd_pkg::REG_QUEUE_COUNT:   cls_cfg_nxt.queue_count = cfg_wdata[3:0];
        fpgd_pkg::REG_SOURCE_NUMBER: begin
          cls_cfg_nxt.source_number = cfg_wdata[2:0];
          reload = 1'b1;
        end
        fpgd_pkg::REG_PARTITION_SLOTS: begin
          psize_nxt = cfg_wdata[fpgd_pkg::PSIZE_W-1:0];
          reload = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // partition bounds from the new settings
  assign psize_eff = (psize_nxt == '0) ? fpgd_pkg::PSIZE_W'(1) : psize_nxt;
  assign start_nxt = fpgd_pkg::POS_W'(fpgd_pkg::POS_W'(cls_cfg_nxt.source_number)
                                      * fpgd_pkg::POS_W'(psize_eff));
  assign last_nxt  = start_nxt + fpgd_pkg::POS_W'(psize_eff) - fpgd_pkg::POS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_cfg_r.source_count  <= 4'd1;
      cls_cfg_r.queue_count   <= 4'd1;
      cls_cfg_r.source_number <= 3'd0;
      psize_r                 <= fpgd_pkg::PSIZE_W'(1024);
      start_r                 <= '0;
      last_r                  <= fpgd_pkg::POS_W'(1023);
    end else begin
      cls_cfg_r <= cls_cfg_nxt;
      psize_r   <= psize_nxt;
      start_r   <= start_nxt;
      last_r    <= last_nxt;
    end
  end

  always_comb begin
    slot_cfg.reload       = reload;
    slot_cfg.reload_start = start_nxt;
    slot_cfg.start        = start_r;
    slot_cfg.last         = last_r;
  end

  fpgd_front #(
    .FLOWS_PER_SOURCE (FLOWS_PER_SOURCE),
    .MAX_QUEUES       (MAX_QUEUES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_cfg   (cls_cfg_r),
    .seed_wr   (seed_wr),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .tick      (in_tdata[0]),
    .fifo_full (fifo_full),
    .push      (push),
    .push_desc (push_desc)
  );

  fpgd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .empty     (fifo_empty),
    .full      (fifo_full)
  );

  fpgd_back #(
    .MAX_QUEUES (MAX_QUEUES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .slot_cfg   (slot_cfg),
    .head_desc  (head_desc),
    .empty      (fifo_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_len    (out_len),
    .out_flow   (out_flow),
    .out_seq    (out_seq),
    .out_queue  (out_queue),
    .out_slot   (out_slot)
  );

  // pack result fields, lowest first
  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_slot, out_queue, out_seq, out_flow, out_len};

endmodule
